[rtl/itp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// itp_pkg: shared types and constants
// operator codes, character classes and the result beat layout
// ---------------------------------------------------------------------------
package itp_pkg;

	// operator codes as kept on the stack
	localparam logic [2:0] CODE_NONE = 3'd0;
	localparam logic [2:0] CODE_LPAR = 3'd1;
	localparam logic [2:0] CODE_ADD  = 3'd2;
	localparam logic [2:0] CODE_SUB  = 3'd3;
	localparam logic [2:0] CODE_MUL  = 3'd4;
	localparam logic [2:0] CODE_DIV  = 3'd5;
	localparam logic [2:0] CODE_POW  = 3'd6;

	// character classes
	localparam logic [2:0] CLS_NONE = 3'd0;
	localparam logic [2:0] CLS_PASS = 3'd1;
	localparam logic [2:0] CLS_LPAR = 3'd2;
	localparam logic [2:0] CLS_RPAR = 3'd3;
	localparam logic [2:0] CLS_OP   = 3'd4;

	localparam logic [7:0] CHAR_LPAR = 8'h28;
	localparam logic [7:0] CHAR_RPAR = 8'h29;
	localparam logic [7:0] CHAR_MUL  = 8'h2A;
	localparam logic [7:0] CHAR_ADD  = 8'h2B;
	localparam logic [7:0] CHAR_SUB  = 8'h2D;
	localparam logic [7:0] CHAR_DIV  = 8'h2F;
	localparam logic [7:0] CHAR_POW  = 8'h5E;

	typedef struct packed {
		logic [7:0] out_char;
		logic       has_char;
		logic       last;
		logic       overflow;
	} res_t;

	function automatic logic [2:0] op_code(input logic [7:0] ch);
		logic [2:0] c;
		case (ch)
			CHAR_ADD: c = CODE_ADD;
			CHAR_SUB: c = CODE_SUB;
			CHAR_MUL: c = CODE_MUL;
			CHAR_DIV: c = CODE_DIV;
			CHAR_POW: c = CODE_POW;
			default:  c = CODE_NONE;
		endcase
		return c;
	endfunction

	function automatic logic [2:0] classify(input logic [7:0] ch);
		logic [2:0] k;
		if ((ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A) ||
			(ch >= 8'h30 && ch <= 8'h39)) begin
			k = CLS_PASS;
		end else if (ch == CHAR_LPAR) begin
			k = CLS_LPAR;
		end else if (ch == CHAR_RPAR) begin
			k = CLS_RPAR;
		end else if (op_code(ch) != CODE_NONE) begin
			k = CLS_OP;
		end else begin
			k = CLS_NONE;
		end
		return k;
	endfunction

	function automatic logic [7:0] code_char(input logic [2:0] c);
		logic [7:0] r;
		case (c)
			CODE_LPAR: r = CHAR_LPAR;
			CODE_ADD:  r = CHAR_ADD;
			CODE_SUB:  r = CHAR_SUB;
			CODE_MUL:  r = CHAR_MUL;
			CODE_DIV:  r = CHAR_DIV;
			CODE_POW:  r = CHAR_POW;
			default:   r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] code_prec(input logic [2:0] c);
		logic [1:0] p;
		case (c)
			CODE_ADD: p = 2'd1;
			CODE_SUB: p = 2'd1;
			CODE_MUL: p = 2'd2;
			CODE_DIV: p = 2'd2;
			CODE_POW: p = 2'd3;
			default:  p = 2'd0;
		endcase
		return p;
	endfunction

endpackage
`default_nettype wire

[rtl/itp_stack_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// itp_stack_ram: operator stack storage
// one write port, one read port, registered read data
// ---------------------------------------------------------------------------
module itp_stack_ram #(
	parameter int STACK_DEPTH = 32
) (
	input  wire                            clk,
	input  wire                            wr_en,
	input  wire [$clog2(STACK_DEPTH)-1:0] wr_addr,
	input  wire [2:0]                      wr_data,
	input  wire                            rd_en,
	input  wire [$clog2(STACK_DEPTH)-1:0] rd_addr,
	output logic [2:0]                     rd_data
);

	// the top entry lives in a register, so one entry fewer is needed here
	localparam int ENTRIES = STACK_DEPTH - 1;

	logic [2:0] mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

[rtl/itp_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// itp_ctrl: shunting-yard sequencer
// keeps the stack top and count, drives the stack memory, issues result beats
// ---------------------------------------------------------------------------
module itp_ctrl
	import itp_pkg::*;
#(
	parameter int STACK_DEPTH = 32
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            acc,
	input  wire [7:0]                      in_char,
	input  wire                            in_fin,
	output logic                           idle,
	input  wire                            slot_free,
	output logic                           emit,
	output res_t                           res,
	output logic                           wr_en,
	output logic [$clog2(STACK_DEPTH)-1:0] wr_addr,
	output logic [2:0]                     wr_data,
	output logic                           rd_en,
	output logic [$clog2(STACK_DEPTH)-1:0] rd_addr,
	input  wire [2:0]                      rd_data
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PROC = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;

	logic [1:0]    state_q;
	logic [2:0]    cls_q;
	logic          fin_q;
	logic          emitted_q;
	logic          ovf_q;
	logic [CW-1:0] cnt_q;
	logic [7:0]    ch_q;
	logic [2:0]    oc_q;
	logic [2:0]    top_q;
	logic          bot_lpar_q;

	logic          emit_req;
	logic [7:0]    emit_char;
	logic          emit_has;
	logic          emit_last;
	logic          do_pop;
	logic          do_push;
	logic [2:0]    push_val;
	logic          do_clear;
	logic [2:0]    next_cls;
	logic [1:0]    next_state;
	logic          go;
	logic          cnt_zero;
	logic          cnt_one;
	logic          cnt_two;
	logic          cnt_full;
	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] cnt_m2;

	assign cnt_zero = (cnt_q == '0);
	assign cnt_one  = (cnt_q == CW'(1));
	assign cnt_two  = (cnt_q == CW'(2));
	assign cnt_full = (cnt_q == CW'(STACK_DEPTH));
	assign cnt_m1   = cnt_q - CW'(1);
	assign cnt_m2   = cnt_q - CW'(2);

	always_comb begin
		emit_req   = 1'b0;
		emit_char  = 8'h00;
		emit_has   = 1'b1;
		emit_last  = 1'b0;
		do_pop     = 1'b0;
		do_push    = 1'b0;
		push_val   = CODE_NONE;
		do_clear   = 1'b0;
		next_cls   = cls_q;
		next_state = state_q;
		if (state_q == ST_PROC) begin
			case (cls_q)
				CLS_PASS: begin
					emit_req  = 1'b1;
					emit_char = ch_q;
					emit_last = fin_q && cnt_zero;
					next_cls  = CLS_NONE;
				end
				CLS_LPAR: begin
					do_push  = 1'b1;
					push_val = CODE_LPAR;
					next_cls = CLS_NONE;
				end
				CLS_RPAR: begin
					if (!cnt_zero && top_q != CODE_LPAR) begin
						emit_req   = 1'b1;
						emit_char  = code_char(top_q);
						// a lone open paren underneath is dropped, nothing follows
						emit_last  = fin_q && (cnt_one || (cnt_two && bot_lpar_q));
						do_pop     = 1'b1;
						next_state = ST_WAIT;
					end else if (!cnt_zero) begin
						// drop the matching open paren
						do_pop     = 1'b1;
						next_state = ST_WAIT;
						next_cls   = CLS_NONE;
					end else begin
						next_cls = CLS_NONE;
					end
				end
				CLS_OP: begin
					if (!cnt_zero && code_prec(top_q) >= code_prec(oc_q)) begin
						emit_req   = 1'b1;
						emit_char  = code_char(top_q);
						do_pop     = 1'b1;
						next_state = ST_WAIT;
					end else begin
						do_push  = 1'b1;
						push_val = oc_q;
						next_cls = CLS_NONE;
					end
				end
				default: begin
					if (!fin_q) begin
						next_state = ST_IDLE;
					end else if (!cnt_zero) begin
						// flush
						emit_req   = 1'b1;
						emit_char  = code_char(top_q);
						emit_last  = cnt_one;
						do_pop     = 1'b1;
						next_state = ST_WAIT;
					end else begin
						if (!emitted_q) begin
							// empty closing beat
							emit_req  = 1'b1;
							emit_has  = 1'b0;
							emit_last = 1'b1;
						end
						do_clear   = 1'b1;
						next_state = ST_IDLE;
					end
				end
			endcase
		end
	end

	assign go   = !emit_req || slot_free;
	assign idle = (state_q == ST_IDLE);
	assign emit = emit_req && slot_free;

	assign res.out_char = emit_char;
	assign res.has_char = emit_has;
	assign res.last     = emit_last;
	assign res.overflow = emit_last && ovf_q;

	// push spills the old top into memory; pop fetches the entry below
	assign wr_en   = go && do_push && !cnt_zero && !cnt_full;
	assign wr_addr = cnt_m1[AW-1:0];
	assign wr_data = top_q;
	assign rd_en   = go && do_pop && !cnt_zero && !cnt_one;
	assign rd_addr = cnt_m2[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cls_q      <= CLS_NONE;
			fin_q      <= 1'b0;
			emitted_q  <= 1'b0;
			ovf_q      <= 1'b0;
			cnt_q      <= '0;
			bot_lpar_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						state_q   <= ST_PROC;
						cls_q     <= classify(in_char);
						fin_q     <= in_fin;
						emitted_q <= 1'b0;
					end
				end
				ST_PROC: begin
					if (go) begin
						state_q <= next_state;
						cls_q   <= next_cls;
						if (emit_req) begin
							emitted_q <= 1'b1;
						end
						if (do_pop) begin
							cnt_q <= cnt_m1;
						end
						if (do_push) begin
							if (cnt_full) begin
								ovf_q <= 1'b1;
							end else begin
								cnt_q <= cnt_q + CW'(1);
							end
						end
						// bottom entry kind, for the last-beat check on close
						if (do_push && cnt_zero) begin
							bot_lpar_q <= (push_val == CODE_LPAR);
						end
						if (do_clear) begin
							cnt_q <= '0;
							ovf_q <= 1'b0;
						end
					end
				end
				ST_WAIT: begin
					state_q <= ST_PROC;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (idle && acc) begin
			ch_q <= in_char;
			oc_q <= op_code(in_char);
		end
		if (state_q == ST_PROC && go && do_push && !cnt_full) begin
			top_q <= push_val;
		end else if (state_q == ST_WAIT) begin
			top_q <= rd_data;
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");
	a_last_needs_fin: assert property (@(posedge clk) disable iff (!arst_n)
		emit && res.last |-> fin_q)
		else $error("last beat outside final character");
	a_wait_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WAIT |-> $past(state_q) == ST_PROC && $past(do_pop))
		else $error("read wait without pop");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		emit && res.last |=> state_q == ST_WAIT || state_q == ST_PROC ||
		state_q == ST_IDLE)
		else $error("bad state after last beat");
`endif

endmodule
`default_nettype wire

[rtl/infix_to_postfix_converter.sv]
`timescale 1ns / 1ps
`default_nettype none
// the input beat is registered into the sequencer, which then emits result beats
// per character: an accept step, a step for each action, a wait state after each
// pop (stack memory read), and a closing step
// results go through one output register, so input is taken while a beat waits
// reset: arst_n clears count, overflow flag, sequencer and output valid;
// stack memory contents are not cleared
// ---------------------------------------------------------------------------
// infix_to_postfix_converter: shunting-yard stream converter
// one infix character per input beat, at most one postfix character per output beat
// ---------------------------------------------------------------------------
module infix_to_postfix_converter
	import itp_pkg::*;
#(
	parameter int STACK_DEPTH = 32
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire [7:0]  s_tdata,  // [7:0] in_char
	input  wire        s_tlast,  // end_of_expr
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [7:0] m_tdata,  // [7:0] out_char
	output logic [1:0] m_tuser,  // [0] has_char, [1] overflow
	output logic       m_tlast   // last beat of the expression
);

	localparam int AW = $clog2(STACK_DEPTH);

	logic          acc;
	logic          idle;
	logic          slot_free;
	logic          emit;
	res_t          res;
	res_t          res_q;
	logic          m_valid_q;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [2:0]    wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [2:0]    rd_data;

	// input side: the sequencer takes a new character only when idle
	assign s_tready = idle;
	assign acc      = s_tvalid && s_tready;

	// output slot frees up in the same cycle its beat is taken
	assign slot_free = !m_valid_q || m_tready;

	itp_ctrl #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.in_char  (s_tdata),
		.in_fin   (s_tlast),
		.idle     (idle),
		.slot_free(slot_free),
		.emit     (emit),
		.res      (res),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data)
	);

	itp_stack_ram #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_stack (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// output register: valid flag under reset, payload without
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = res_q.out_char;
	assign m_tuser  = {res_q.overflow, res_q.has_char};
	assign m_tlast  = res_q.last;

endmodule
`default_nettype wire
